### rtl/core/cpsf_pkg.sv
// cpsf_pkg: shared types and codes of the cashless payment session controller
// command codes, event codes, one-hot mode type and the step result struct
// no dependencies
package cpsf_pkg;

  localparam logic [3:0] FN_DEPOSIT   = 4'd0;
  localparam logic [3:0] FN_RESET     = 4'd1;
  localparam logic [3:0] FN_ENABLE    = 4'd2;
  localparam logic [3:0] FN_DISABLE   = 4'd3;
  localparam logic [3:0] FN_SALE      = 4'd4;
  localparam logic [3:0] FN_SALE_OK   = 4'd5;
  localparam logic [3:0] FN_SALE_FAIL = 4'd6;
  localparam logic [3:0] FN_CLOSE     = 4'd7;
  localparam logic [3:0] FN_TICK      = 4'd8;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BEGIN    = 3'd1;
  localparam logic [2:0] EV_END      = 3'd2;
  localparam logic [2:0] EV_APPROVED = 3'd3;
  localparam logic [2:0] EV_DENIED   = 3'd4;

  localparam logic [2:0] MC_IDLE     = 3'd0;
  localparam logic [2:0] MC_DISABLED = 3'd1;
  localparam logic [2:0] MC_ENABLED  = 3'd2;
  localparam logic [2:0] MC_SESSION  = 3'd3;
  localparam logic [2:0] MC_VENDING  = 3'd4;

  localparam logic [15:0] TIMEOUT_RST = 16'd60000;

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_DISABLED = 5'b00010,
    MODE_ENABLED  = 5'b00100,
    MODE_SESSION  = 5'b01000,
    MODE_VENDING  = 5'b10000
  } mode_t;

  // outcome of one command: up to two events, shared ok and mode
  typedef struct packed {
    logic        ok;
    logic [2:0]  ev0;
    logic [31:0] val0;
    logic [2:0]  ev1;
    logic [31:0] val1;
    logic        two;
    logic [2:0]  mode;
  } step_res_t;

  // one result item as held in the output buffer
  typedef struct packed {
    logic        ok;
    logic [2:0]  ev;
    logic [31:0] val;
    logic [2:0]  mode;
    logic        last;
  } res_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_IDLE:     c = MC_IDLE;
      MODE_DISABLED: c = MC_DISABLED;
      MODE_ENABLED:  c = MC_ENABLED;
      MODE_SESSION:  c = MC_SESSION;
      MODE_VENDING:  c = MC_VENDING;
      default:       c = MC_IDLE;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/cashless_payment_session_fsm.sv
// cashless_payment_session_fsm: top level of the payment session controller
// input register, timeout register and two-entry result buffer around
// cpsf_core; depends on cpsf_pkg and cpsf_core
//
// usage:
//   in_*   : one command item per handshake, in_tuser = command code,
//            in_tdata = amount (credit for deposit, price for sale)
//   out_*  : one or two result items per command, out_tlast marks the final
//            one; a session timeout that reopens a session gives two items
//   cfg_*  : writes the 16-bit session timeout in ticks, always ready
// flow: a command is registered on acceptance and decoded once the result buffer
//   can take it; its first result is registered there and shows on out_tvalid.
// throughput: one command per cycle while each gives a single result and out_tready
//   stays high; a command with two results holds the result buffer until both leave.
// reset (rst_n low, synchronous): mode idle, credit zero, flag and timer
//   cleared, timeout back to 60000, both channels empty.
// stall: while out_tready is low the result buffer holds; one more command
//   waits in the input register, after which in_tready drops.
module cashless_payment_session_fsm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // [3:0] func
  input  logic [31:0] in_tdata,   // [31:0] amount
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] event_code
  output logic [39:0] out_tdata,  // [0] ok, [32:1] event_value, [35:33] mode, [39:36] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] sess_ticks
);
  import cpsf_pkg::*;

  logic        ivld_r;
  logic [3:0]  func_r;
  logic [31:0] amount_r;
  logic [15:0] timeout_r;
  logic [1:0]  ocnt_r;
  res_t        res0_r, res1_r;
  step_res_t   step;
  logic        out_fire;
  logic        can_load;
  logic        fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      timeout_r <= cfg_data;
    end
  end

  assign out_fire  = out_tvalid && out_tready;
  // buffer can take a new command's results if empty or its last item leaves now
  assign can_load  = (ocnt_r == 2'd0) || (ocnt_r == 2'd1 && out_tready);
  assign fire      = ivld_r && can_load;
  assign in_tready = !ivld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_tready) begin
      ivld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r   <= in_tuser;
      amount_r <= in_tdata;
    end
  end

  cpsf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .func    (func_r),
    .amount  (amount_r),
    .timeout (timeout_r),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else if (fire) begin
      ocnt_r <= step.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res0_r <= '{ok: step.ok, ev: step.ev0, val: step.val0, mode: step.mode,
                  last: !step.two};
      res1_r <= '{ok: step.ok, ev: step.ev1, val: step.val1, mode: step.mode,
                  last: 1'b1};
    end else if (out_fire && ocnt_r == 2'd2) begin
      res0_r <= res1_r;
    end
  end

  assign out_tvalid = (ocnt_r != 2'd0);
  assign out_tuser  = res0_r.ev;
  assign out_tdata  = {4'd0, res0_r.mode, res0_r.val, res0_r.ok};
  assign out_tlast  = res0_r.last;

endmodule

### rtl/core/cpsf_core.sv
// cpsf_core: session state (mode, credit, enabled flag, timer) and the
// combinational command decode that updates it; depends on cpsf_pkg
module cpsf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [3:0]          func,
  input  logic [31:0]         amount,
  input  logic [15:0]         timeout,
  output cpsf_pkg::step_res_t res
);
  import cpsf_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [31:0] credit_r, credit_nxt;
  logic        en_r, en_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  logic        run_r, run_nxt;
  mode_t       idle_mode;

  // mode reached once a session or vend ends without a new session starting
  assign idle_mode = en_r ? MODE_ENABLED : MODE_DISABLED;

  always_comb begin
    mode_nxt   = mode_r;
    credit_nxt = credit_r;
    en_nxt     = en_r;
    tcnt_nxt   = tcnt_r;
    run_nxt    = run_r;
    res.ok     = 1'b1;
    res.ev0    = EV_NONE;
    res.val0   = '0;
    res.ev1    = EV_NONE;
    res.val1   = '0;
    res.two    = 1'b0;
    case (func)
      FN_DEPOSIT: begin
        credit_nxt = amount;
        if (mode_r == MODE_ENABLED && amount != '0) begin
          tcnt_nxt = timeout;
          run_nxt  = 1'b1;
          mode_nxt = MODE_SESSION;
          res.ev0  = EV_BEGIN;
          res.val0 = amount;
        end
      end
      FN_RESET: begin
        credit_nxt = '0;
        en_nxt     = 1'b0;
        mode_nxt   = MODE_DISABLED;
      end
      FN_ENABLE: begin
        en_nxt = 1'b1;
        if (mode_r == MODE_DISABLED) begin
          if (credit_r != '0) begin
            tcnt_nxt = timeout;
            run_nxt  = 1'b1;
            mode_nxt = MODE_SESSION;
            res.ev0  = EV_BEGIN;
            res.val0 = credit_r;
          end else begin
            mode_nxt = MODE_ENABLED;
          end
        end
      end
      FN_DISABLE: begin
        en_nxt = 1'b0;
        if (mode_r == MODE_ENABLED) begin
          mode_nxt = MODE_DISABLED;
        end
      end
      FN_SALE: begin
        if (mode_r != MODE_SESSION) begin
          res.ok = 1'b0;
        end else begin
          run_nxt = 1'b0;
          if (credit_r >= amount) begin
            mode_nxt = MODE_VENDING;
            res.ev0  = EV_APPROVED;
            res.val0 = amount;
          end else begin
            credit_nxt = '0;
            mode_nxt   = idle_mode;
            res.ev0    = EV_DENIED;
          end
        end
      end
      FN_SALE_OK, FN_SALE_FAIL: begin
        if (mode_r != MODE_VENDING) begin
          res.ok = 1'b0;
        end else begin
          credit_nxt = '0;
          mode_nxt   = idle_mode;
          res.ev0    = EV_END;
        end
      end
      FN_CLOSE: begin
        run_nxt    = 1'b0;
        credit_nxt = '0;
        mode_nxt   = idle_mode;
        res.ev0    = EV_END;
      end
      FN_TICK: begin
        if (run_r) begin
          if (tcnt_r <= 16'd1) begin
            tcnt_nxt = '0;
            run_nxt  = 1'b0;
            if (mode_r == MODE_SESSION) begin
              if (en_r && credit_r != '0) begin
                // credit still held: reopen, then report the old session's end
                tcnt_nxt = timeout;
                run_nxt  = 1'b1;
                res.ev0  = EV_BEGIN;
                res.val0 = credit_r;
                res.ev1  = EV_END;
                res.two  = 1'b1;
              end else begin
                mode_nxt = idle_mode;
                res.ev0  = EV_END;
              end
            end
          end else begin
            tcnt_nxt = tcnt_r - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
    res.mode = mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      credit_r <= '0;
      en_r     <= 1'b0;
      tcnt_r   <= '0;
      run_r    <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      credit_r <= credit_nxt;
      en_r     <= en_nxt;
      tcnt_r   <= tcnt_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule
